### rtl/framed_fsk_tone_modulator_defines.svh
// assertion macros for the framed fsk tone modulator
`ifndef FRAMED_FSK_TONE_MODULATOR_DEFINES_SVH
`define FRAMED_FSK_TONE_MODULATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FFTM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fftm assertion failed");

// next-cycle implication, checked outside reset
`define FFTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fftm assertion failed");

`endif

### rtl/fftm_pkg.sv
// shared constants, codes and sine table builder for the fsk tone modulator
package fftm_pkg;

  localparam int FRAMES_DEF      = 64;
  localparam int PHASE_BITS_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int INC_W   = 16;
  localparam int CNT_W   = 10;
  localparam int ST_W    = 3;
  localparam int TONE_W  = 3;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 16;
  localparam int QTAB_W  = 24;
  localparam int QTAB_N  = 65;

  // frame states
  localparam logic [ST_W-1:0] ST_WAIT = 3'd0;
  localparam logic [ST_W-1:0] ST_HEAD = 3'd1;
  localparam logic [ST_W-1:0] ST_CUE  = 3'd2;
  localparam logic [ST_W-1:0] ST_DATA = 3'd3;
  localparam logic [ST_W-1:0] ST_FOOT = 3'd4;

  // tone codes
  localparam logic [TONE_W-1:0] TN_SILENT  = 3'd0;
  localparam logic [TONE_W-1:0] TN_CARRIER = 3'd1;
  localparam logic [TONE_W-1:0] TN_ZA      = 3'd2;
  localparam logic [TONE_W-1:0] TN_ZB      = 3'd3;
  localparam logic [TONE_W-1:0] TN_OA      = 3'd4;
  localparam logic [TONE_W-1:0] TN_OB      = 3'd5;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_CARRIER = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ZERO_A  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_ZERO_B  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ONE_A   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ONE_B   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_CTRL    = 3'd5;
  localparam logic [CFG_AW-1:0] REG_BIT     = 3'd6;

  localparam logic [CNT_W-1:0] CTRL_PERIODS_RST = 10'd20;

  typedef logic [QTAB_W-1:0] qtab_t [QTAB_N];

  // quarter wave amplitudes, polynomial sine in q16, evaluated at elaboration
  function automatic qtab_t build_qtab(int sample_bits);
    qtab_t tab;
    longint unsigned fs;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned inner;
    longint unsigned mid;
    longint unsigned y;
    longint unsigned amp;
    fs = (64'd1 << (sample_bits - 1)) - 64'd1;
    for (int k = 0; k < QTAB_N; k++) begin
      z     = 64'(k) << 10;
      z2    = (z * z) >> 16;
      inner = 64'd42047 - ((z2 * 64'd4640) >> 16);
      mid   = 64'd102944 - ((z2 * inner) >> 16);
      y     = (z * mid) >> 16;
      if (y > 64'd65536) y = 64'd65536;
      amp = (y * fs + 64'd32768) >> 16;
      if (amp > fs) amp = fs;
      tab[k] = QTAB_W'(amp);
    end
    return tab;
  endfunction

endpackage

### rtl/fftm_if.sv
// request channels of the fsk tone modulator: period input, sample output, register writes
interface fftm_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic bit_available;
  logic bit_value;

  modport source (output valid, start_req, bit_available, bit_value, input ready);
  modport sink   (input valid, start_req, bit_available, bit_value, output ready);
endinterface

interface fftm_out_if #(
  parameter int SAMPLE_BITS = fftm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_in_period;
  logic                          bit_taken;
  logic [2:0]                    frame_phase;

  modport source (output valid, sample, last_in_period, bit_taken, frame_phase, input ready);
  modport sink   (input valid, sample, last_in_period, bit_taken, frame_phase, output ready);
endinterface

interface fftm_cfg_if;
  import fftm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

### rtl/framed_fsk_tone_modulator.sv
// framed fsk tone modulator: frame sequencer, phase accumulator and sine rom
// an accepted period request loads the burst registers; each of its samples then goes out through the output register
// FRAMES samples per period request, one sample per cycle while the output is not stalled by back-pressure
// the next request is taken in the cycle the last sample of the current one is issued
// reset: synchronous, active low; clears sequencer, phase, burst control and output valid, and loads register defaults
// register writes are always accepted; they must only happen while the block is idle
module framed_fsk_tone_modulator #(
  parameter int FRAMES      = fftm_pkg::FRAMES_DEF,
  parameter int PHASE_BITS  = fftm_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = fftm_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  fftm_cfg_if.sink      cfg_ch,
  fftm_in_if.sink       in_ch,
  fftm_out_if.source    out_ch
);
  import fftm_pkg::*;

  `include "framed_fsk_tone_modulator_defines.svh"

  // frame counter width, one bit minimum when a period holds one sample
  localparam int FCW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [FCW-1:0] FLAST = FCW'(FRAMES - 1);

  // quarter-wave rom contents, built at elaboration
  localparam qtab_t QTAB = build_qtab(SAMPLE_BITS);

  // configuration registers
  logic [INC_W-1:0] carrier_inc_r, zero_a_inc_r, zero_b_inc_r, one_a_inc_r, one_b_inc_r;
  logic [CNT_W-1:0] ctrl_periods_r, bit_periods_r;

  // frame sequencer state, advanced once per accepted period
  logic [ST_W-1:0]   state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TONE_W-1:0] tone_r, tone_nxt;
  logic [ST_W-1:0]   entered;
  logic              taken;
  logic [PHASE_BITS-1:0] step_nxt;

  // per-period burst: step and flags held while FRAMES samples go out
  logic                  busy_r;
  logic [FCW-1:0]        fcnt_r;
  logic [PHASE_BITS-1:0] step_r;
  logic                  taken_r;
  logic [ST_W-1:0]       entered_r;
  logic [PHASE_BITS-1:0] phase_r;

  // output register
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_last_r;
  logic                          out_taken_r;
  logic [ST_W-1:0]               out_phase_r;

  logic in_acc, issue, issue_last;

  // sine lookup signals
  logic [7:0]             rom_idx;
  logic [6:0]             rom_k;
  logic [SAMPLE_BITS-1:0] amp;
  logic [SAMPLE_BITS-1:0] sample_nxt;

  // handshakes: a sample issues when the output register is free or being drained
  assign issue        = busy_r && (!out_valid_r || out_ch.ready);
  assign issue_last   = issue && (fcnt_r == FLAST);
  assign in_ch.ready  = !busy_r || issue_last;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_inc_r  <= '0;
      zero_a_inc_r   <= '0;
      zero_b_inc_r   <= '0;
      one_a_inc_r    <= '0;
      one_b_inc_r    <= '0;
      ctrl_periods_r <= CTRL_PERIODS_RST;
      bit_periods_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        REG_CARRIER: carrier_inc_r  <= cfg_ch.data;
        REG_ZERO_A:  zero_a_inc_r   <= cfg_ch.data;
        REG_ZERO_B:  zero_b_inc_r   <= cfg_ch.data;
        REG_ONE_A:   one_a_inc_r    <= cfg_ch.data;
        REG_ONE_B:   one_b_inc_r    <= cfg_ch.data;
        REG_CTRL:    ctrl_periods_r <= cfg_ch.data[CNT_W-1:0];
        REG_BIT:     bit_periods_r  <= cfg_ch.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // frame sequencer: next state, counter and tone for the period being accepted
  always_comb begin
    state_nxt = (state_r > ST_FOOT) ? ST_WAIT : state_r;
    // a start request is honored only while waiting
    if (state_nxt == ST_WAIT && in_ch.start_req) state_nxt = ST_HEAD;
    entered  = state_nxt;
    cnt_nxt  = cnt_r;
    tone_nxt = tone_r;
    taken    = 1'b0;

    unique case (state_nxt)
      ST_WAIT: tone_nxt = TN_SILENT;
      ST_HEAD, ST_FOOT: begin
        // carrier header or footer, control_periods+1 periods long
        tone_nxt = TN_CARRIER;
        if (cnt_nxt == ctrl_periods_r) begin
          state_nxt = (state_nxt == ST_HEAD) ? ST_CUE : ST_WAIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_nxt + CNT_W'(1);
        end
      end
      ST_CUE: begin
        // silent cue, data rules run in the same period
        state_nxt = ST_DATA;
        tone_nxt  = TN_SILENT;
      end
      default: ;
    endcase

    // bits exhausted: go to footer, tone of this period unchanged
    if (state_nxt == ST_DATA && !in_ch.bit_available) begin
      state_nxt = ST_FOOT;
      cnt_nxt   = '0;
    end

    if (state_nxt == ST_DATA) begin
      if (cnt_nxt == bit_periods_r) begin
        // take the bit and alternate between the two tones of its value
        if (in_ch.bit_value) tone_nxt = (tone_nxt == TN_OA) ? TN_OB : TN_OA;
        else                 tone_nxt = (tone_nxt == TN_ZA) ? TN_ZB : TN_ZA;
        taken   = 1'b1;
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_nxt + CNT_W'(1);
      end
    end
  end

  // tone to phase step, silent and unused codes give no step
  always_comb begin
    unique case (tone_nxt)
      TN_CARRIER: step_nxt = PHASE_BITS'(carrier_inc_r);
      TN_ZA:      step_nxt = PHASE_BITS'(zero_a_inc_r);
      TN_ZB:      step_nxt = PHASE_BITS'(zero_b_inc_r);
      TN_OA:      step_nxt = PHASE_BITS'(one_a_inc_r);
      TN_OB:      step_nxt = PHASE_BITS'(one_b_inc_r);
      default:    step_nxt = '0;
    endcase
  end

  // sequencer registers update once per accepted period
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT;
      cnt_r   <= '0;
      tone_r  <= TN_SILENT;
    end else if (in_acc) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      tone_r  <= tone_nxt;
    end
  end

  // burst control: a new period takes over right after the last sample of the previous one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fcnt_r <= '0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
      fcnt_r <= '0;
    end else if (issue_last) begin
      busy_r <= 1'b0;
    end else if (issue) begin
      fcnt_r <= fcnt_r + FCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      step_r    <= step_nxt;
      taken_r   <= taken;
      entered_r <= entered;
    end
  end

  // phase accumulator, wraps modulo a full turn; frozen between bursts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (issue) begin
      phase_r <= phase_r + step_r;
    end
  end

  // sine rom: top 8 phase bits, quarter table mirrored and negated by quadrant
  assign rom_idx    = phase_r[PHASE_BITS-1 -: 8];
  assign rom_k      = rom_idx[6] ? (7'd64 - {1'b0, rom_idx[5:0]}) : {1'b0, rom_idx[5:0]};
  assign amp        = QTAB[rom_k][SAMPLE_BITS-1:0];
  assign sample_nxt = rom_idx[7] ? (SAMPLE_BITS'(0) - amp) : amp;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (issue) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_sample_r <= sample_nxt;
      out_last_r   <= (fcnt_r == FLAST);
      out_taken_r  <= taken_r;
      out_phase_r  <= entered_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.sample         = out_sample_r;
  assign out_ch.last_in_period = out_last_r;
  assign out_ch.bit_taken      = out_taken_r;
  assign out_ch.frame_phase    = out_phase_r;

  // a request during a burst only lands on its final sample
  `FFTM_ASSERT_NOW(a_acc_only_at_end, in_acc && busy_r, issue_last)
  // the final sample of a burst carries the period marker
  `FFTM_ASSERT_NEXT(a_last_marked, issue_last, out_valid_r && out_last_r)
  // a bit is only consumed in a cue or data period
  `FFTM_ASSERT_NOW(a_taken_in_data, out_valid_r && out_taken_r,
                   out_phase_r == ST_DATA || out_phase_r == ST_CUE)
  // phase holds while no sample issues
  `FFTM_ASSERT_NEXT(a_phase_frozen, !issue, $stable(phase_r))
endmodule

### verif/tb_top.sv
// self-checking testbench for the framed fsk tone modulator: directed frames, then random traffic
module tb_top;
  import fftm_pkg::*;

  // run shape
  localparam int FRAME_LEN      = FRAMES_DEF;
  localparam int RUN_ITEMS      = 440;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int REPORT_CAP     = 40;
  localparam longint unsigned FULL_SCALE = (64'd1 << (SAMPLE_BITS_DEF - 1)) - 64'd1;

  // one period request as the driver puts it on the wire
  typedef struct packed {
    logic start;
    logic avail;
    logic value;
  } period_req_t;

  // one predicted sample with its side-band flags
  typedef struct packed {
    logic [SAMPLE_BITS_DEF-1:0] level;
    logic                       last;
    logic                       taken;
    logic [ST_W-1:0]            phase;
  } sample_exp_t;

  logic clk;
  logic rst_n;

  fftm_in_if  in_ch();
  fftm_out_if out_ch();
  fftm_cfg_if cfg_ch();

  framed_fsk_tone_modulator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // pending period requests, filled by the stimulus block and drained by the driver
  period_req_t pending_periods[$];
  // samples predicted for accepted requests, oldest first
  sample_exp_t expected_samples[$];

  // shadow copy of the register file
  logic [INC_W-1:0] carrier_step = '0;
  logic [INC_W-1:0] zero_a_step  = '0;
  logic [INC_W-1:0] zero_b_step  = '0;
  logic [INC_W-1:0] one_a_step   = '0;
  logic [INC_W-1:0] one_b_step   = '0;
  logic [CNT_W-1:0] header_len   = CTRL_PERIODS_RST;
  logic [CNT_W-1:0] bit_len      = '0;

  // shadow copy of the frame sequencer and phase accumulator
  logic [ST_W-1:0]           frame_st  = ST_WAIT;
  logic [CNT_W-1:0]          period_cnt = '0;
  logic [TONE_W-1:0]         tone      = TN_SILENT;
  logic [PHASE_BITS_DEF-1:0] phase_acc = '0;

  // bookkeeping
  int items_queued       = 0;
  int requests_accepted  = 0;
  int samples_checked    = 0;
  int reg_writes         = 0;
  int frames_started     = 0;
  int bits_taken         = 0;
  int errors             = 0;

  period_req_t next_req;
  sample_exp_t want;

  // clock, 10 units per cycle
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // quarter-wave amplitude: odd polynomial in q16, truncated products, rounded to full scale
  function automatic logic [SAMPLE_BITS_DEF-1:0] quarter_level(int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned poly;
    longint unsigned y;
    longint unsigned lvl;
    x    = 64'(k) << 10;
    x2   = (x * x) >> 16;
    poly = 64'd42047 - ((x2 * 64'd4640) >> 16);
    poly = 64'd102944 - ((x2 * poly) >> 16);
    y    = (x * poly) >> 16;
    if (y > 64'd65536) y = 64'd65536;
    lvl = (y * FULL_SCALE + 64'd32768) >> 16;
    if (lvl > FULL_SCALE) lvl = FULL_SCALE;
    return lvl[SAMPLE_BITS_DEF-1:0];
  endfunction

  // full wave from the top 8 phase bits: odd quadrants mirror, upper half negates
  function automatic logic [SAMPLE_BITS_DEF-1:0] sine_level(logic [PHASE_BITS_DEF-1:0] ph);
    logic [7:0]                 idx;
    int                         k;
    logic [SAMPLE_BITS_DEF-1:0] lvl;
    idx = ph[PHASE_BITS_DEF-1 -: 8];
    k   = idx[6] ? 64 - int'(idx[5:0]) : int'(idx[5:0]);
    lvl = quarter_level(k);
    return idx[7] ? SAMPLE_BITS_DEF'(0) - lvl : lvl;
  endfunction

  // one period: sequencer update, then FRAME_LEN samples from the accumulator
  function automatic void predict_period(logic start, logic avail, logic value);
    logic [ST_W-1:0]           entered;
    logic                      taken;
    logic [PHASE_BITS_DEF-1:0] step;
    // unused state codes behave as waiting
    if (frame_st > ST_FOOT) frame_st = ST_WAIT;
    if (frame_st == ST_WAIT && start) begin
      frame_st = ST_HEAD;
      frames_started++;
    end
    entered = frame_st;
    taken   = 1'b0;
    case (frame_st)
      ST_WAIT: begin
        tone = TN_SILENT;
      end
      ST_HEAD, ST_FOOT: begin
        // carrier for header and footer, counter runs up to the control length
        tone = TN_CARRIER;
        if (period_cnt == header_len) begin
          frame_st   = (frame_st == ST_HEAD) ? ST_CUE : ST_WAIT;
          period_cnt = '0;
        end else begin
          period_cnt = period_cnt + CNT_W'(1);
        end
      end
      ST_CUE: begin
        // silent cue, falls straight into the data rules below
        frame_st = ST_DATA;
        tone     = TN_SILENT;
      end
      default: ;
    endcase
    // out of bits: go to the footer, keep the current tone for this period
    if (frame_st == ST_DATA && !avail) begin
      frame_st   = ST_FOOT;
      period_cnt = '0;
    end
    if (frame_st == ST_DATA) begin
      if (period_cnt == bit_len) begin
        // each bit value alternates between its own pair of tones
        if (value) tone = (tone == TN_OA) ? TN_OB : TN_OA;
        else       tone = (tone == TN_ZA) ? TN_ZB : TN_ZA;
        taken      = 1'b1;
        period_cnt = '0;
        bits_taken++;
      end else begin
        period_cnt = period_cnt + CNT_W'(1);
      end
    end
    case (tone)
      TN_CARRIER: step = carrier_step;
      TN_ZA:      step = zero_a_step;
      TN_ZB:      step = zero_b_step;
      TN_OA:      step = one_a_step;
      TN_OB:      step = one_b_step;
      default:    step = '0;
    endcase
    for (int i = 0; i < FRAME_LEN; i++) begin
      expected_samples.push_back('{level: sine_level(phase_acc),
                                   last:  1'(i == FRAME_LEN - 1),
                                   taken: taken,
                                   phase: entered});
      phase_acc = phase_acc + step;
    end
  endfunction

  // register write as seen by the shadow copy, counts keep the low 10 bits
  function automatic void apply_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    case (idx)
      REG_CARRIER: carrier_step = val;
      REG_ZERO_A:  zero_a_step  = val;
      REG_ZERO_B:  zero_b_step  = val;
      REG_ONE_A:   one_a_step   = val;
      REG_ONE_B:   one_b_step   = val;
      REG_CTRL:    header_len   = val[CNT_W-1:0];
      REG_BIT:     bit_len      = val[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  // idle share in percent: sender light / receiver heavy, then swapped, then none
  function automatic int idle_pct(bit sender_side);
    if (requests_accepted < RUN_ITEMS / 3) return sender_side ? 11 : 54;
    if (requests_accepted < 2 * RUN_ITEMS / 3) return sender_side ? 54 : 11;
    return 0;
  endfunction

  task automatic flag_mismatch(string field, int exp_val, int got_val);
    errors++;
    if (errors <= REPORT_CAP)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, got_val);
  endtask

  // driver: one request slot, refilled at the edge that accepts the current request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_period(in_ch.start_req, in_ch.bit_available, in_ch.bit_value);
        requests_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_periods.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          next_req = pending_periods.pop_front();
          in_ch.start_req     <= next_req.start;
          in_ch.bit_available <= next_req.avail;
          in_ch.bit_value     <= next_req.value;
          in_ch.valid         <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, every accepted sample checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: unexpected sample %0d with nothing pending",
                     $time, $signed(out_ch.sample));
        end else begin
          want = expected_samples.pop_front();
          samples_checked++;
          if (out_ch.sample !== want.level)
            flag_mismatch("sample", int'($signed(want.level)), int'($signed(out_ch.sample)));
          if (out_ch.last_in_period !== want.last)
            flag_mismatch("last_in_period", int'(want.last), int'(out_ch.last_in_period));
          if (out_ch.bit_taken !== want.taken)
            flag_mismatch("bit_taken", int'(want.taken), int'(out_ch.bit_taken));
          if (out_ch.frame_phase !== want.phase)
            flag_mismatch("frame_phase", int'(want.phase), int'(out_ch.frame_phase));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // watchdog: a run of cycles without a single handshake ends the run once it reaches the watchdog limit
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no handshake for %0d cycles, %0d samples still pending",
             $time, WATCHDOG_LIMIT, expected_samples.size());
    $display("simulation failed");
    $finish;
  end

  task automatic queue_period(logic start, logic avail, logic value);
    pending_periods.push_back('{start: start, avail: avail, value: value});
    items_queued++;
  endtask

  // block until every queued request is accepted and every predicted sample has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (requests_accepted != items_queued || expected_samples.size() != 0);
  endtask

  // single register write; valid goes low before the task returns, so it is never dropped and raised in one step
  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_reg(idx, val);
    reg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [INC_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'($urandom_range(1, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // fresh register set; upper bits of the count registers are junk and must be dropped
  task automatic load_random_settings();
    logic [CNT_W-1:0] ctrl_val;
    logic [CNT_W-1:0] bit_val;
    ctrl_val = ($urandom_range(0, 9) < 8) ? CNT_W'($urandom_range(0, 3))
                                          : CNT_W'($urandom_range(4, 8));
    bit_val  = ($urandom_range(0, 9) < 8) ? CNT_W'($urandom_range(0, 2))
                                          : CNT_W'($urandom_range(3, 5));
    write_reg(REG_CARRIER, pick_step());
    write_reg(REG_ZERO_A, pick_step());
    write_reg(REG_ZERO_B, pick_step());
    write_reg(REG_ONE_A, pick_step());
    write_reg(REG_ONE_B, pick_step());
    write_reg(REG_CTRL, {6'($urandom), ctrl_val});
    write_reg(REG_BIT, {6'($urandom), bit_val});
  endtask

  // well-formed frame: start, header, cue plus data bits, drop-out, footer, a little waiting
  task automatic queue_frame();
    int nbits;
    nbits = $urandom_range(0, 6);
    queue_period(1'b1, 1'($urandom), 1'($urandom));
    // the rest of the header ignores every field
    repeat (header_len) queue_period(1'($urandom), 1'($urandom), 1'($urandom));
    // cue period counts as the first data period
    repeat (nbits * (bit_len + 1)) queue_period(1'($urandom), 1'b1, 1'($urandom));
    queue_period(1'($urandom), 1'b0, 1'($urandom));
    repeat (header_len + 1) queue_period(1'($urandom), 1'($urandom), 1'($urandom));
    repeat ($urandom_range(0, 2)) queue_period(1'b0, 1'($urandom), 1'($urandom));
  endtask

  // enough idle-line periods to bring any frame back to waiting with a clear counter
  task automatic queue_flush();
    repeat (2 * (header_len + 1) + 3) queue_period(1'b0, 1'b0, 1'($urandom));
  endtask

  // stimulus and end of run
  initial begin
    int frames_since_cfg;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.start_req      = 1'b0;
    in_ch.bit_available  = 1'b0;
    in_ch.bit_value      = 1'b0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.addr          = '0;
    cfg_ch.data          = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults: waiting line, silent, phase stuck at zero
    queue_period(1'b0, 1'b0, 1'b0);
    queue_period(1'b0, 1'b1, 1'b1);
    wait_drained();

    // extreme steps, two-period header and footer, one period per bit
    write_reg(REG_CARRIER, 16'hFFFF);
    write_reg(REG_ZERO_A, 16'h0001);
    write_reg(REG_ZERO_B, 16'h8000);
    write_reg(REG_ONE_A, 16'h0400);
    write_reg(REG_ONE_B, 16'h0000);
    write_reg(REG_CTRL, 16'h0001);
    write_reg(REG_BIT, 16'h0000);
    queue_period(1'b1, 1'b1, 1'b0);  // start, first header period
    queue_period(1'b1, 1'b0, 1'b1);  // start ignored inside the header
    queue_period(1'b0, 1'b1, 1'b0);  // cue, first zero bit
    queue_period(1'b0, 1'b1, 1'b0);  // zero again, second zero tone
    queue_period(1'b0, 1'b1, 1'b1);  // switch to one
    queue_period(1'b1, 1'b1, 1'b1);  // one again, start ignored in data
    queue_period(1'b0, 1'b1, 1'b0);
    queue_period(1'b0, 1'b1, 1'b1);
    queue_period(1'b0, 1'b0, 1'b1);  // bits run out, tone held
    queue_period(1'b0, 1'b0, 1'b0);  // footer
    queue_period(1'b0, 1'b0, 1'b0);
    queue_period(1'b0, 1'b1, 1'b1);  // back to waiting, phase frozen

    // no bits at all: footer straight from the cue period
    queue_period(1'b1, 1'b1, 1'b0);
    queue_period(1'b0, 1'b1, 1'b1);
    queue_period(1'b0, 1'b0, 1'b0);
    queue_period(1'b0, 1'b0, 1'b1);
    queue_period(1'b0, 1'b0, 1'b1);
    wait_drained();

    // zero-length header, then the bit length drops below the running counter
    write_reg(REG_CTRL, 16'h0000);
    write_reg(REG_BIT, 16'h0003);
    queue_period(1'b1, 1'b1, 1'b0);
    queue_period(1'b0, 1'b1, 1'b1);
    queue_period(1'b0, 1'b1, 1'b1);
    wait_drained();
    write_reg(REG_BIT, 16'h0001);
    queue_period(1'b0, 1'b1, 1'b0);  // counter above its limit keeps counting
    queue_period(1'b0, 1'b1, 1'b0);
    queue_period(1'b0, 1'b0, 1'b0);  // footer clears it
    queue_period(1'b0, 1'b0, 1'b0);
    wait_drained();

    // largest counts: header cut short by a later limit, bit never completes
    write_reg(REG_CTRL, 16'h03FF);
    write_reg(REG_BIT, 16'hFFFF);
    queue_period(1'b1, 1'b0, 1'b0);
    wait_drained();
    write_reg(REG_CTRL, 16'h0001);
    queue_period(1'b0, 1'b1, 1'b1);
    queue_period(1'b0, 1'b1, 1'b0);
    queue_period(1'b0, 1'b1, 1'b1);
    queue_period(1'b0, 1'b0, 1'b1);
    queue_period(1'b0, 1'b0, 1'b0);
    queue_period(1'b0, 1'b0, 1'b0);

    // random traffic: mostly whole frames, some noise, new settings every few frames
    frames_since_cfg = 6;
    while (items_queued < RUN_ITEMS) begin
      if (frames_since_cfg >= 6) begin
        queue_flush();
        wait_drained();
        load_random_settings();
        frames_since_cfg = 0;
      end
      if ($urandom_range(99) < 85) begin
        queue_frame();
      end else begin
        repeat ($urandom_range(1, 6)) queue_period(1'($urandom), 1'($urandom), 1'($urandom));
      end
      frames_since_cfg++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d period requests, %0d frames, %0d bits taken, %0d register writes",
             requests_accepted, frames_started, bits_taken, reg_writes);
    $display("checked %0d samples, %0d mismatches", samples_checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/fftm_pkg.sv
rtl/fftm_if.sv
rtl/framed_fsk_tone_modulator.sv
verif/tb_top.sv
